### hw/rtl/slle_pkg.sv
// shared types and constants for the static linked list engine
`timescale 1ns / 1ps

package slle_pkg;

    localparam int POS_W    = 7;
    localparam int LEN_W    = 7;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INS_FREE,
        ST_INS_POP,
        ST_WALK,
        ST_INS_LINK,
        ST_DEL_UNL,
        ST_DEL_FREE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   removed_value;
        logic [LEN_W-1:0]    list_length;
    } res_t;

endpackage

### hw/rtl/slle_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps

interface slle_req_if import slle_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     command;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] item_value;

    modport source (output valid, command, position, item_value, input ready);
    modport sink   (input valid, command, position, item_value, output ready);
endinterface

interface slle_rsp_if import slle_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] removed_value;
    logic [LEN_W-1:0]         list_length;

    modport source (output valid, status, removed_value, list_length, input ready);
    modport sink   (input valid, status, removed_value, list_length, output ready);
endinterface

### hw/rtl/slle_ram.sv
// simple dual port memory, one write and one registered read per cycle
`timescale 1ns / 1ps

module slle_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

### hw/rtl/slle_seq.sv
// sequencer: free chain pop/push, link walk and splice over the two memories
`timescale 1ns / 1ps

module slle_seq import slle_pkg::*; #(
    parameter int SLOTS       = 128,
    parameter int VALUE_WIDTH = 32,
    localparam int AW         = $clog2(SLOTS)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    slle_req_if.sink               request,
    output logic                   res_valid,
    output res_t                   res,
    input  logic                   res_ready,
    output logic [AW-1:0]          rd_addr,
    input  logic [AW-1:0]          link_rd_data,
    input  logic [VALUE_WIDTH-1:0] value_rd_data,
    output logic                   link_we,
    output logic [AW-1:0]          link_waddr,
    output logic [AW-1:0]          link_wdata,
    output logic                   value_we,
    output logic [AW-1:0]          value_waddr,
    output logic [VALUE_WIDTH-1:0] value_wdata
);

    localparam int CW = ((AW > POS_W) ? AW : POS_W) + 1;

    state_t                  state_reg, state_next;
    logic [AW-1:0]           free_head_reg, free_head_next;
    logic [AW-1:0]           list_head_reg, list_head_next;
    logic [AW-1:0]           count_reg, count_next;
    logic [AW-1:0]           clr_reg, clr_next;
    logic [AW-1:0]           cur_reg, cur_next;
    logic [AW-1:0]           slot_reg, slot_next;
    logic                    cmd_reg, cmd_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [POS_W-1:0]        steps_reg, steps_next;
    logic [VALUE_WIDTH-1:0]  val_reg, val_next;
    status_t                 status_reg, status_next;
    logic [DATA_W-1:0]       removed_reg, removed_next;

    logic [CW-1:0]           pos_x;
    logic [CW-1:0]           cnt_x;
    logic                    ins_bad;
    logic                    del_bad;
    logic                    clr_last;
    logic [AW-1:0]           clr_link;
    logic                    pos_is_one;
    logic signed [VALUE_WIDTH-1:0] value_rd_s;

    assign pos_x      = CW'(request.position);
    assign cnt_x      = CW'(count_reg);
    assign ins_bad    = (request.position == '0) || (pos_x > (cnt_x + CW'(1)));
    assign del_bad    = (request.position == '0) || (pos_x > cnt_x);
    assign clr_last   = (clr_reg == AW'(SLOTS - 1));
    assign clr_link   = ((clr_reg == '0) || (clr_reg >= AW'(SLOTS - 2))) ? '0 : clr_reg + AW'(1);
    assign pos_is_one = (pos_reg == POS_W'(1));
    assign value_rd_s = value_rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            free_head_reg <= AW'(1);
            list_head_reg <= '0;
            count_reg     <= '0;
            clr_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            list_head_reg <= list_head_next;
            count_reg     <= count_next;
            clr_reg       <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        slot_reg    <= slot_next;
        cmd_reg     <= cmd_next;
        pos_reg     <= pos_next;
        steps_reg   <= steps_next;
        val_reg     <= val_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (request.valid)
                begin
                    if (request.command == CMD_INSERT)
                    begin
                        state_next = ((free_head_reg == '0) || ins_bad) ? ST_DONE : ST_INS_FREE;
                    end
                    else if (del_bad)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = (request.position == POS_W'(1)) ? ST_DEL_UNL : ST_WALK;
                    end
                end
            end
            ST_INS_FREE: state_next = ST_INS_POP;
            ST_INS_POP:  state_next = pos_is_one ? ST_DONE : ST_WALK;
            ST_WALK:
            begin
                if (steps_reg == '0)
                begin
                    state_next = (cmd_reg == CMD_INSERT) ? ST_INS_LINK : ST_DEL_UNL;
                end
            end
            ST_INS_LINK: state_next = ST_DONE;
            ST_DEL_UNL:  state_next = ST_DEL_FREE;
            ST_DEL_FREE: state_next = ST_DONE;
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath registers
    always_comb
    begin
        free_head_next = free_head_reg;
        list_head_next = list_head_reg;
        count_next     = count_reg;
        clr_next       = clr_reg;
        cur_next       = cur_reg;
        slot_next      = slot_reg;
        cmd_next       = cmd_reg;
        pos_next       = pos_reg;
        steps_next     = steps_reg;
        val_next       = val_reg;
        status_next    = status_reg;
        removed_next   = removed_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
            end
            ST_IDLE:
            begin
                if (request.valid)
                begin
                    cmd_next     = request.command;
                    pos_next     = request.position;
                    steps_next   = request.position - POS_W'(2);
                    val_next     = VALUE_WIDTH'(request.item_value);
                    cur_next     = list_head_reg;
                    slot_next    = list_head_reg;
                    removed_next = '0;
                    status_next  = STATUS_OK;
                    if (request.command == CMD_INSERT)
                    begin
                        if (free_head_reg == '0)
                        begin
                            status_next = STATUS_FULL;
                        end
                        else if (ins_bad)
                        begin
                            status_next = STATUS_RANGE;
                        end
                    end
                    else if (del_bad)
                    begin
                        status_next = STATUS_RANGE;
                    end
                end
            end
            ST_INS_FREE:
            begin
                slot_next = free_head_reg;
            end
            ST_INS_POP:
            begin
                free_head_next = link_rd_data;
                if (pos_is_one)
                begin
                    list_head_next = slot_reg;
                    count_next     = count_reg + AW'(1);
                end
            end
            ST_WALK:
            begin
                if (steps_reg != '0)
                begin
                    cur_next   = link_rd_data;
                    steps_next = steps_reg - POS_W'(1);
                end
                else if (cmd_reg == CMD_DELETE)
                begin
                    slot_next = link_rd_data;
                end
            end
            ST_INS_LINK:
            begin
                count_next = count_reg + AW'(1);
            end
            ST_DEL_UNL:
            begin
                if (pos_is_one)
                begin
                    list_head_next = link_rd_data;
                end
                removed_next = DATA_W'(value_rd_s);
            end
            ST_DEL_FREE:
            begin
                free_head_next = slot_reg;
                count_next     = count_reg - AW'(1);
            end
            default:
            begin
            end
        endcase
    end

    // memory control and handshake
    always_comb
    begin
        request.ready = (state_reg == ST_IDLE);
        res_valid     = (state_reg == ST_DONE);
        rd_addr       = list_head_reg;
        link_we       = 1'b0;
        link_waddr    = slot_reg;
        link_wdata    = free_head_reg;
        value_we      = 1'b0;
        value_waddr   = free_head_reg;
        value_wdata   = val_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                link_we    = 1'b1;
                link_waddr = clr_reg;
                link_wdata = clr_link;
            end
            ST_INS_FREE:
            begin
                rd_addr  = free_head_reg;
                value_we = 1'b1;
            end
            ST_INS_POP:
            begin
                if (pos_is_one)
                begin
                    link_we    = 1'b1;
                    link_waddr = slot_reg;
                    link_wdata = list_head_reg;
                end
            end
            ST_WALK:
            begin
                rd_addr = link_rd_data;
                if ((steps_reg == '0) && (cmd_reg == CMD_INSERT))
                begin
                    link_we    = 1'b1;
                    link_waddr = slot_reg;
                    link_wdata = link_rd_data;
                end
            end
            ST_INS_LINK:
            begin
                link_we    = 1'b1;
                link_waddr = cur_reg;
                link_wdata = slot_reg;
            end
            ST_DEL_UNL:
            begin
                if (!pos_is_one)
                begin
                    link_we    = 1'b1;
                    link_waddr = cur_reg;
                    link_wdata = link_rd_data;
                end
            end
            ST_DEL_FREE:
            begin
                link_we    = 1'b1;
                link_waddr = slot_reg;
                link_wdata = free_head_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign res.status        = status_reg;
    assign res.removed_value = removed_reg;
    assign res.list_length   = LEN_W'(count_reg);

endmodule

### hw/rtl/static_linked_list_engine_unit.sv
// top level of the static linked list engine: memories, sequencer, result register
`timescale 1ns / 1ps

// Ordered list of up to SLOTS-2 values kept in a link memory and a value memory,
// with unused slots on a free chain. A request beat inserts item_value at a 1-based
// position (1 is the head, up to length+1) or deletes the node at a position; each
// request gives exactly one response beat with status, the removed value (zero
// unless a delete succeeds) and the list length afterwards. One request is worked
// at a time. A rejected request goes straight to its response; insert or delete at
// position 1 needs no walk, and a later position walks the list, reading one link
// per cycle through the single read port of the link memory. After reset a clearing
// pass over every slot builds the free chain in the link memory; no request is
// accepted until it ends. A finished result sits in the output register, so the
// next request is taken while the response waits.
module static_linked_list_engine_unit import slle_pkg::*; #(
    parameter int SLOTS       = 128,
    parameter int VALUE_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    slle_req_if.sink   request,
    slle_rsp_if.source response
);

    localparam int AW = $clog2(SLOTS);

    logic                   res_valid;
    res_t                   res;
    logic                   res_ready;
    logic [AW-1:0]          rd_addr;
    logic [AW-1:0]          link_rd_data;
    logic [VALUE_WIDTH-1:0] value_rd_data;
    logic                   link_we;
    logic [AW-1:0]          link_waddr;
    logic [AW-1:0]          link_wdata;
    logic                   value_we;
    logic [AW-1:0]          value_waddr;
    logic [VALUE_WIDTH-1:0] value_wdata;

    logic                   out_valid_reg, out_valid_next;
    res_t                   out_res_reg, out_res_next;
    logic                   res_take;

    // next-links, built by the clearing pass after reset
    slle_ram #(
        .DEPTH (SLOTS),
        .WIDTH (AW)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (link_we),
        .wr_addr (link_waddr),
        .wr_data (link_wdata),
        .rd_addr (rd_addr),
        .rd_data (link_rd_data)
    );

    // stored values; only those at slots that an insert wrote are ever used
    slle_ram #(
        .DEPTH (SLOTS),
        .WIDTH (VALUE_WIDTH)
    ) u_value_ram (
        .clk     (clk),
        .wr_en   (value_we),
        .wr_addr (value_waddr),
        .wr_data (value_wdata),
        .rd_addr (rd_addr),
        .rd_data (value_rd_data)
    );

    // one operation at a time; reads of an entry always finish before it is
    // rewritten, so the memories need no forwarding
    slle_seq #(
        .SLOTS       (SLOTS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .request       (request),
        .res_valid     (res_valid),
        .res           (res),
        .res_ready     (res_ready),
        .rd_addr       (rd_addr),
        .link_rd_data  (link_rd_data),
        .value_rd_data (value_rd_data),
        .link_we       (link_we),
        .link_waddr    (link_waddr),
        .link_wdata    (link_wdata),
        .value_we      (value_we),
        .value_waddr   (value_waddr),
        .value_wdata   (value_wdata)
    );

    // output register: takes a result when empty or being drained
    assign res_ready = !out_valid_reg || response.ready;
    assign res_take  = res_valid && res_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (response.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign response.valid         = out_valid_reg;
    assign response.status        = out_res_reg.status;
    assign response.removed_value = out_res_reg.removed_value;
    assign response.list_length   = out_res_reg.list_length;

    // a failed operation never reports a removed value
    assert property (@(posedge clk) disable iff (!rst_n)
        (response.valid && (response.status != STATUS_OK)) |-> (response.removed_value == '0))
    else $error("removed value nonzero on failed operation");

    // a result handed to the output register shows up as a response beat
    assert property (@(posedge clk) disable iff (!rst_n)
        res_take |=> response.valid)
    else $error("result lost at output register");

    // the sequencer never takes a request while it still holds a result
    assert property (@(posedge clk) disable iff (!rst_n)
        request.ready |-> !res_valid)
    else $error("request taken with a result pending");

endmodule

### tb/static_linked_list_engine_unit_tb.sv
// self-checking testbench for the static linked list engine
`timescale 1ns / 1ps

module static_linked_list_engine_unit_tb;
    import slle_pkg::*;

    localparam int SLOTS       = 128;
    localparam int CAPACITY    = SLOTS - 2;
    localparam int IDLE_PCT    = 34;
    localparam int HOLD_AT     = 900;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 200;
    localparam int CYCLE_LIMIT = 1_500_000;

    // one request beat as queued by the stimulus
    typedef struct {
        logic              cmd;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;
    } list_op_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    slle_req_if req_ch ();
    slle_rsp_if rsp_ch ();

    static_linked_list_engine_unit #(
        .SLOTS       (SLOTS),
        .VALUE_WIDTH (DATA_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_ch),
        .response (rsp_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // list predictor: link and value memories, free chain, list head
    // ------------------------------------------------------------------
    logic [POS_W-1:0]  link_mem  [SLOTS];
    logic [DATA_W-1:0] value_mem [SLOTS];
    logic [POS_W-1:0]  free_slot;
    logic [POS_W-1:0]  head_slot;
    int                node_total;

    list_op_t pending_ops [$];
    res_t     expected_results [$];
    int       gen_len;        // list length as seen by the stimulus generator
    int       ops_accepted;
    int       error_count;
    int       cycle_count;

    // slot of the node just ahead of a 1-based position (position >= 2)
    function automatic logic [POS_W-1:0] node_before(logic [POS_W-1:0] pos);
        logic [POS_W-1:0] cur;
        int               steps;
        cur   = head_slot;
        steps = int'(pos) - 2;
        for (int j = 0; j < steps; j++)
            cur = link_mem[cur];
        return cur;
    endfunction

    // apply one request to the predicted list, return the response it gives
    function automatic res_t apply_list_op(logic cmd, logic [POS_W-1:0] pos,
                                           logic [DATA_W-1:0] val);
        res_t             r;
        logic [POS_W-1:0] slot;
        logic [POS_W-1:0] prev;
        r        = '0;
        r.status = STATUS_OK;
        if (cmd == CMD_INSERT)
        begin
            // full list wins over a bad position
            if (free_slot == '0)
                r.status = STATUS_FULL;
            else if (pos == 0 || int'(pos) > node_total + 1)
                r.status = STATUS_RANGE;
            else
            begin
                slot            = free_slot;
                free_slot       = link_mem[slot];
                value_mem[slot] = val;
                if (pos == 1)
                begin
                    link_mem[slot] = head_slot;
                    head_slot      = slot;
                end
                else
                begin
                    prev           = node_before(pos);
                    link_mem[slot] = link_mem[prev];
                    link_mem[prev] = slot;
                end
                node_total++;
            end
        end
        else
        begin
            if (pos == 0 || int'(pos) > node_total)
                r.status = STATUS_RANGE;
            else
            begin
                if (pos == 1)
                begin
                    slot      = head_slot;
                    head_slot = link_mem[slot];
                end
                else
                begin
                    prev           = node_before(pos);
                    slot           = link_mem[prev];
                    link_mem[prev] = link_mem[slot];
                end
                r.removed_value = value_mem[slot];
                // freed slot goes back on top of the free chain
                link_mem[slot]  = free_slot;
                free_slot       = slot;
                node_total--;
            end
        end
        r.list_length = node_total[LEN_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // idling control
    // ------------------------------------------------------------------
    // a stretch with no idling on either side, early in the fill phase
    wire calm = (ops_accepted >= 40) && (ops_accepted < 260);

    // request driver: pops the pending queue, predicts at each accepted beat
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        list_op_t next_op;
        if (!rst_n)
        begin
            req_ch.valid      <= 1'b0;
            req_ch.command    <= CMD_INSERT;
            req_ch.position   <= '0;
            req_ch.item_value <= '0;
            ops_accepted      <= 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                expected_results.push_back(apply_list_op(req_ch.command,
                    req_ch.position, req_ch.item_value));
                ops_accepted <= ops_accepted + 1;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_ops.size() != 0 &&
                    (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    next_op            = pending_ops.pop_front();
                    req_ch.valid      <= 1'b1;
                    req_ch.command    <= next_op.cmd;
                    req_ch.position   <= next_op.pos;
                    req_ch.item_value <= next_op.val;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // response ready: random stalls plus one long hold-off so the engine backs up
    int  hold_left;
    bit  hold_done;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end
        else if (!hold_done && ops_accepted >= HOLD_AT)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_done    <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else
            rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // response monitor: each beat against the oldest expectation
    always @(posedge clk)
    begin : check_responses
        res_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected response beat status %0d removed %0d length %0d",
                         $time, rsp_ch.status, rsp_ch.removed_value, rsp_ch.list_length);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (rsp_ch.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, rsp_ch.status);
                    error_count++;
                end
                if (rsp_ch.removed_value !== want.removed_value)
                begin
                    $display("%0t: removed_value expected %h actual %h",
                             $time, want.removed_value, rsp_ch.removed_value);
                    error_count++;
                end
                if (rsp_ch.list_length !== want.list_length)
                begin
                    $display("%0t: list_length expected %0d actual %0d",
                             $time, want.list_length, rsp_ch.list_length);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    // queue one beat, tracking the length the engine will have after it
    task automatic queue_op(logic cmd, int pos, logic [DATA_W-1:0] val);
        list_op_t op;
        op.cmd = cmd;
        op.pos = pos[POS_W-1:0];
        op.val = val;
        if (cmd == CMD_INSERT && gen_len < CAPACITY && pos >= 1 && pos <= gen_len + 1)
            gen_len++;
        else if (cmd == CMD_DELETE && pos >= 1 && pos <= gen_len)
            gen_len--;
        pending_ops.push_back(op);
    endtask

    // mostly legal positions biased to head and tail, some random noise
    task automatic queue_random(int count, int insert_pct);
        logic cmd;
        int   pos;
        int   top;
        for (int k = 0; k < count; k++)
        begin
            cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_DELETE;
            top = (cmd == CMD_INSERT) ? gen_len + 1 : gen_len;
            if ($urandom_range(0, 99) < 12 || top == 0)
                pos = $urandom_range(0, 127);
            else
            begin
                case ($urandom_range(0, 3))
                    0:       pos = 1;
                    1:       pos = top;
                    default: pos = $urandom_range(1, top);
                endcase
            end
            queue_op(cmd, pos, $urandom());
        end
    endtask

    // hold the sender until the engine has answered everything
    task automatic wait_drained();
        while (pending_ops.size() != 0 || req_ch.valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        error_count = 0;
        gen_len     = 0;
        // free chain 1..SLOTS-2, null slot 0 and unused last slot unlinked
        for (int i = 0; i < SLOTS; i++)
            link_mem[i] = POS_W'(i + 1);
        link_mem[0]         = '0;
        link_mem[SLOTS - 2] = '0;
        link_mem[SLOTS - 1] = '0;
        free_slot  = POS_W'(1);
        head_slot  = '0;
        node_total = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: bad positions on an empty list
        queue_op(CMD_DELETE, 1, 32'h0000_0000);
        queue_op(CMD_DELETE, 0, 32'hFFFF_FFFF);
        queue_op(CMD_INSERT, 0, 32'h1234_5678);
        queue_op(CMD_INSERT, 2, 32'h1234_5678);
        queue_op(CMD_INSERT, 127, 32'hFFFF_FFFF);
        // build a short list at head, tail and middle with extreme values
        queue_op(CMD_INSERT, 1, 32'h7FFF_FFFF);
        queue_op(CMD_INSERT, 2, 32'h8000_0000);
        queue_op(CMD_INSERT, 1, 32'h0000_0000);
        queue_op(CMD_INSERT, 2, 32'hFFFF_FFFF);
        queue_op(CMD_INSERT, 5, 32'h5555_5555);
        // one past the legal end for each command
        queue_op(CMD_INSERT, 7, 32'hAAAA_AAAA);
        queue_op(CMD_DELETE, 6, 32'h0000_0000);
        // delete middle, head, tail
        queue_op(CMD_DELETE, 3, 32'h0000_0000);
        queue_op(CMD_DELETE, 1, 32'h0000_0000);
        queue_op(CMD_DELETE, 3, 32'h0000_0000);
        queue_op(CMD_INSERT, 3, 32'hAAAA_AAAA);
        queue_op(CMD_DELETE, 127, 32'h0000_0000);
        // drain to empty, then once more on the empty list
        queue_op(CMD_DELETE, 1, 32'h0000_0000);
        queue_op(CMD_DELETE, 1, 32'h0000_0000);
        queue_op(CMD_DELETE, 1, 32'h0000_0000);
        queue_op(CMD_DELETE, 1, 32'h0000_0000);
        wait_drained();

        // fill past capacity so inserts run into the full list
        queue_random(500, 80);
        wait_drained();

        // mixed traffic, the long receiver hold-off lands in here
        queue_random(700, 50);
        // drain toward empty, then mixed again
        queue_random(400, 20);
        queue_random(330, 50);
        wait_drained();

        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/slle_pkg.sv
hw/rtl/slle_if.sv
hw/rtl/slle_ram.sv
hw/rtl/slle_seq.sv
hw/rtl/static_linked_list_engine_unit.sv
tb/static_linked_list_engine_unit_tb.sv
